// File: hw/rtl/msd_pkg.sv
package msd_pkg;

    // field and datapath widths
    localparam int RAW_W        = 16;
    localparam int SPEED_W      = 16;
    localparam int CUR_W        = 16;
    localparam int TEMP_W       = 10;
    localparam int DEG_W        = 8;
    localparam int CUR_SCALED_W = 20;
    localparam int RATE_W       = 4;
    localparam int FACT_W       = 17;
    localparam int TDROP_W      = 14;
    localparam int CDROP_W      = 20;
    localparam int CTRL_W       = 6;
    localparam int FLT_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // bit-serial step counts
    localparam int DEG_STEPS   = RAW_W;
    localparam int DEG_CNT_W   = $clog2(DEG_STEPS);
    localparam int MUL_STEPS   = FACT_W;
    localparam int DIV_STEPS   = SPEED_W;
    localparam int STEP_CNT_W  = $clog2(MUL_STEPS);
    localparam int DEG_REM_W   = 7;

    // arithmetic constants
    localparam logic [DEG_REM_W-1:0]    DEG_DIV   = 7'd100;
    localparam logic [FACT_W-1:0]       TEMP_BASE = 17'd100;
    localparam logic [FACT_W-1:0]       CUR_BASE  = 17'd100000;
    localparam logic [DEG_W-1:0]        TEMP_HYST = 8'd3;
    localparam logic [CUR_SCALED_W-1:0] CUR_HYST  = 20'd2000;
    localparam logic [CUR_SCALED_W-1:0] CUR_UNIT  = 20'd10;
    localparam logic [RATE_W-1:0]       RATE_MAX  = 4'd10;

    // register reset values
    localparam logic [CTRL_W-1:0] CONTROL_RST       = 6'd0;
    localparam logic [DEG_W-1:0]  IGBT_START_RST    = 8'd80;
    localparam logic [DEG_W-1:0]  WIND_START_RST    = 8'd100;
    localparam logic [CUR_W-1:0]  CUR_START_RST     = 16'd1000;
    localparam logic [DEG_W-1:0]  IGBT_FAULT_RST    = 8'd110;
    localparam logic [DEG_W-1:0]  WIND_FAULT_RST    = 8'd130;
    localparam logic [CUR_W-1:0]  CUR_CUTOFF_RST    = 16'd2000;
    localparam logic [RATE_W-1:0] RAMP_RATE_RST     = 4'd0;

    // control register bits
    localparam int CTL_EN_CUR   = 0;
    localparam int CTL_EN_WIND  = 1;
    localparam int CTL_EN_IGBT  = 2;
    localparam int CTL_BYP_IGBT = 3;
    localparam int CTL_BYP_WIND = 4;
    localparam int CTL_BYP_CUR  = 5;

    // fault flag bits
    localparam int FLT_IGBT = 0;
    localparam int FLT_WIND = 1;
    localparam int FLT_CUR  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTROL    = 3'd0,
        REG_IGBT_START = 3'd1,
        REG_WIND_START = 3'd2,
        REG_CUR_START  = 3'd3,
        REG_IGBT_FAULT = 3'd4,
        REG_WIND_FAULT = 3'd5,
        REG_CUR_CUTOFF = 3'd6,
        REG_RAMP_RATE  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [RAW_W-1:0]   igbt_temp_centideg;
        logic [RAW_W-1:0]   winding_temp_centideg;
        logic [CUR_W-1:0]   current_ma;
        logic [SPEED_W-1:0] speed_rpm;
    } msd_in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] target_speed_rpm;
        logic               igbt_fault;
        logic               winding_fault;
        logic               current_fault;
    } msd_out_t;

    typedef enum logic [1:0] {
        SCL_IDLE,
        SCL_MUL,
        SCL_DIV
    } scl_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEG,
        ST_CMP,
        ST_DROP,
        ST_FACT,
        ST_SCALE,
        ST_UPD,
        ST_OUT
    } msd_state_t;

endpackage

// File: hw/rtl/msd_cdiv.sv
module msd_cdiv
    import msd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAW_W-1:0]  dividend,
    output logic [TEMP_W-1:0] quotient,
    output logic              done
);

    logic                 busy_reg, busy_next;
    logic [DEG_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEG_REM_W-1:0] rem_reg, rem_next;
    logic [RAW_W-1:0]     sh_reg, sh_next;

    logic [DEG_REM_W:0]   trial;
    logic [DEG_REM_W:0]   diff;
    logic                 ge;
    logic                 last;

    // one restoring step by the constant divisor per cycle
    assign trial = {rem_reg, sh_reg[RAW_W-1]};
    assign ge    = trial >= {1'b0, DEG_DIV};
    assign diff  = trial - {1'b0, DEG_DIV};
    assign last  = cnt_reg == DEG_CNT_W'(DEG_STEPS - 1);

    assign done     = busy_reg && last;
    assign quotient = sh_reg[TEMP_W-1:0];

    // next values
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            sh_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEG_REM_W-1:0] : trial[DEG_REM_W-1:0];
            sh_next  = {sh_reg[RAW_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

endmodule

// File: hw/rtl/msd_scale.sv
module msd_scale
    import msd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] speed,
    input  logic [FACT_W-1:0]  factor,
    input  logic [FACT_W-1:0]  base,
    output logic [SPEED_W-1:0] quotient,
    output logic               done
);

    scl_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SPEED_W-1:0]    hi_reg, hi_next;
    logic [FACT_W-1:0]     lo_reg, lo_next;
    logic [FACT_W-1:0]     rem_reg, rem_next;

    logic [SPEED_W:0]      mul_sum;
    logic [FACT_W:0]       trial;
    logic [FACT_W:0]       diff;
    logic                  div_ge;
    logic                  mul_last;
    logic                  div_last;
    logic                  load;

    // shift-add product step, factor consumed lsb first
    assign mul_sum  = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? speed : {SPEED_W{1'b0}})};
    // restoring quotient step, remaining product bits msb first
    assign trial    = {rem_reg, lo_reg[SPEED_W-1]};
    assign div_ge   = trial >= {1'b0, base};
    assign diff     = trial - {1'b0, base};
    assign mul_last = cnt_reg == STEP_CNT_W'(MUL_STEPS - 1);
    assign div_last = cnt_reg == STEP_CNT_W'(DIV_STEPS - 1);

    assign quotient = lo_reg[SPEED_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SCL_IDLE: if (start)    state_next = SCL_MUL;
            SCL_MUL:  if (mul_last) state_next = SCL_DIV;
            SCL_DIV:  if (div_last) state_next = SCL_IDLE;
            default:                state_next = SCL_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        load = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            SCL_IDLE: load = start;
            SCL_MUL:  ;
            SCL_DIV:  done = div_last;
            default:  ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next = cnt_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        rem_next = rem_reg;
        unique case (state_reg)
            SCL_IDLE:
            begin
                if (load)
                begin
                    hi_next  = '0;
                    lo_next  = factor;
                    cnt_next = '0;
                end
            end
            SCL_MUL:
            begin
                if (mul_last)
                begin
                    // product high part seeds the remainder, which is below base
                    rem_next = FACT_W'(mul_sum);
                    lo_next  = FACT_W'(lo_reg[FACT_W-1:1]);
                    cnt_next = '0;
                end
                else
                begin
                    hi_next  = mul_sum[SPEED_W:1];
                    lo_next  = {mul_sum[0], lo_reg[FACT_W-1:1]};
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SCL_DIV:
            begin
                rem_next = div_ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
                lo_next  = {lo_reg[FACT_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCL_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rem_reg <= rem_next;
    end

endmodule

// File: hw/rtl/motor_speed_derating_unit.sv
// Speed derating for a motor drive: each input beat (IGBT and winding
// temperature, filtered current, commanded speed) updates the held target of
// every enabled channel and latches the unbypassed sticky over-limit faults;
// one output beat carries the minimum held target with the fault flags. The
// unit takes one sample at a time, and no new one until the last result is
// loaded into the output register, where it waits while the next sample is
// taken. Two bit-serial passes do the work: a 16-step divide of the
// temperatures to whole degrees, and a 33-step shift-add multiply with
// restoring divide that scales the speed in all three channels at once. The
// user must write registers through the plain write port only while no sample
// is in flight; the unit itself does not enforce this.
module motor_speed_derating_unit
    import msd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msd_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output msd_out_t              out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    msd_state_t state_reg, state_next;

    // configuration registers
    logic [CTRL_W-1:0] control_reg;
    logic [DEG_W-1:0]  igbt_start_reg;
    logic [DEG_W-1:0]  wind_start_reg;
    logic [CUR_W-1:0]  cur_start_reg;
    logic [DEG_W-1:0]  igbt_fault_reg;
    logic [DEG_W-1:0]  wind_fault_reg;
    logic [CUR_W-1:0]  cur_cutoff_reg;
    logic [RATE_W-1:0] rate_reg;

    // sample registers
    logic [CUR_W-1:0]   ma_reg;
    logic [SPEED_W-1:0] speed_reg;

    // compare stage
    logic              ige_reg, ilt_reg, wge_reg, wlt_reg, cge_reg, clt_reg;
    logic [TEMP_W-1:0] iexc_reg, wexc_reg;
    logic [CUR_W-1:0]  cexc_reg;

    // drop stage
    logic [TDROP_W-1:0] idrop_reg, wdrop_reg;
    logic [CDROP_W-1:0] cdrop_reg;

    // held targets and faults
    logic [SPEED_W-1:0] ihold_reg, whold_reg, chold_reg;
    logic [FLT_W-1:0]   fault_reg;

    // output register
    logic     out_valid_reg;
    msd_out_t out_data_reg;

    // fsm outputs
    logic deg_start;
    logic scl_start;
    logic out_load;

    // unit connections
    logic [TEMP_W-1:0]  t_igbt, t_wind;
    logic               deg_done_i, deg_done_w, deg_done;
    logic [FACT_W-1:0]  ifact, wfact, cfact;
    logic [SPEED_W-1:0] iscl, wscl, cscl;
    logic               scl_done_i, scl_done_w, scl_done_c, scl_done;

    // compare stage logic
    logic [DEG_W-1:0]        irest, wrest;
    logic [CUR_SCALED_W-1:0] start_ma, cut_ma, crest;
    logic [CUR_SCALED_W-1:0] ma_wide;
    logic [FLT_W-1:0]        fault_hit;

    // minimum of enabled targets
    logic [SPEED_W-1:0] min_speed;

    logic en_cur, en_wind, en_igbt;

    assign en_cur  = control_reg[CTL_EN_CUR];
    assign en_wind = control_reg[CTL_EN_WIND];
    assign en_igbt = control_reg[CTL_EN_IGBT];

    // centidegrees to whole degrees
    msd_cdiv u_cdiv_igbt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (deg_start),
        .dividend (in_data.igbt_temp_centideg),
        .quotient (t_igbt),
        .done     (deg_done_i)
    );

    msd_cdiv u_cdiv_wind (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (deg_start),
        .dividend (in_data.winding_temp_centideg),
        .quotient (t_wind),
        .done     (deg_done_w)
    );

    assign deg_done = deg_done_i & deg_done_w;

    // speed scaling, one unit per channel
    msd_scale u_scale_igbt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scl_start),
        .speed    (speed_reg),
        .factor   (ifact),
        .base     (TEMP_BASE),
        .quotient (iscl),
        .done     (scl_done_i)
    );

    msd_scale u_scale_wind (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scl_start),
        .speed    (speed_reg),
        .factor   (wfact),
        .base     (TEMP_BASE),
        .quotient (wscl),
        .done     (scl_done_w)
    );

    msd_scale u_scale_cur (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scl_start),
        .speed    (speed_reg),
        .factor   (cfact),
        .base     (CUR_BASE),
        .quotient (cscl),
        .done     (scl_done_c)
    );

    assign scl_done = scl_done_i & scl_done_w & scl_done_c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_DEG;
            ST_DEG:   if (deg_done) state_next = ST_CMP;
            ST_CMP:   state_next = ST_DROP;
            ST_DROP:  state_next = ST_FACT;
            ST_FACT:  state_next = ST_SCALE;
            ST_SCALE: if (scl_done) state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        deg_start = 1'b0;
        scl_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                deg_start = in_valid;
            end
            ST_FACT:  scl_start = 1'b1;
            ST_OUT:   out_load  = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    // thresholds and restore levels
    assign ma_wide   = CUR_SCALED_W'(ma_reg);
    assign start_ma  = CUR_SCALED_W'(cur_start_reg) * CUR_UNIT;
    assign cut_ma    = CUR_SCALED_W'(cur_cutoff_reg) * CUR_UNIT;
    assign crest     = (start_ma >= CUR_HYST) ? start_ma - CUR_HYST : '0;
    assign irest     = (igbt_start_reg >= TEMP_HYST) ? igbt_start_reg - TEMP_HYST : '0;
    assign wrest     = (wind_start_reg >= TEMP_HYST) ? wind_start_reg - TEMP_HYST : '0;

    // over-limit checks, bypass blocks new latching
    assign fault_hit[FLT_IGBT] = !control_reg[CTL_BYP_IGBT] && (t_igbt > TEMP_W'(igbt_fault_reg));
    assign fault_hit[FLT_WIND] = !control_reg[CTL_BYP_WIND] && (t_wind > TEMP_W'(wind_fault_reg));
    assign fault_hit[FLT_CUR]  = !control_reg[CTL_BYP_CUR] && (ma_wide > cut_ma);

    // factor from drop, zero once the drop reaches the base
    assign ifact = (FACT_W'(idrop_reg) >= TEMP_BASE) ? '0 : TEMP_BASE - FACT_W'(idrop_reg);
    assign wfact = (FACT_W'(wdrop_reg) >= TEMP_BASE) ? '0 : TEMP_BASE - FACT_W'(wdrop_reg);
    assign cfact = (cdrop_reg >= CDROP_W'(CUR_BASE)) ? '0
                 : FACT_W'(CDROP_W'(CUR_BASE) - cdrop_reg);

    // minimum over enabled held targets, seeded with the speed unless current is on
    always_comb
    begin
        min_speed = speed_reg;
        if (en_cur)
        begin
            min_speed = chold_reg;
        end
        if (en_wind && (whold_reg < min_speed))
        begin
            min_speed = whold_reg;
        end
        if (en_igbt && (ihold_reg < min_speed))
        begin
            min_speed = ihold_reg;
        end
    end

    // fsm, holds, faults and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ihold_reg     <= '0;
            whold_reg     <= '0;
            chold_reg     <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CMP)
            begin
                fault_reg <= fault_reg | fault_hit;
            end
            if (state_reg == ST_UPD)
            begin
                if (en_igbt)
                begin
                    if (ige_reg)
                    begin
                        ihold_reg <= iscl;
                    end
                    else if (ilt_reg)
                    begin
                        ihold_reg <= speed_reg;
                    end
                end
                if (en_wind)
                begin
                    if (wge_reg)
                    begin
                        whold_reg <= wscl;
                    end
                    else if (wlt_reg)
                    begin
                        whold_reg <= speed_reg;
                    end
                end
                if (en_cur)
                begin
                    if (cge_reg)
                    begin
                        chold_reg <= cscl;
                    end
                    else if (clt_reg)
                    begin
                        chold_reg <= speed_reg;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample, compare and drop registers
    always_ff @(posedge clk)
    begin
        if (deg_start)
        begin
            ma_reg    <= in_data.current_ma;
            speed_reg <= in_data.speed_rpm;
        end
        if (state_reg == ST_CMP)
        begin
            ige_reg  <= t_igbt >= TEMP_W'(igbt_start_reg);
            ilt_reg  <= t_igbt < TEMP_W'(irest);
            iexc_reg <= t_igbt - TEMP_W'(igbt_start_reg);
            wge_reg  <= t_wind >= TEMP_W'(wind_start_reg);
            wlt_reg  <= t_wind < TEMP_W'(wrest);
            wexc_reg <= t_wind - TEMP_W'(wind_start_reg);
            cge_reg  <= ma_wide >= start_ma;
            clt_reg  <= ma_wide < crest;
            cexc_reg <= ma_reg - start_ma[CUR_W-1:0];
        end
        if (state_reg == ST_DROP)
        begin
            idrop_reg <= TDROP_W'(rate_reg) * TDROP_W'(iexc_reg);
            wdrop_reg <= TDROP_W'(rate_reg) * TDROP_W'(wexc_reg);
            cdrop_reg <= CDROP_W'(rate_reg) * CDROP_W'(cexc_reg);
        end
        if (out_load)
        begin
            out_data_reg.target_speed_rpm <= min_speed;
            out_data_reg.igbt_fault       <= fault_reg[FLT_IGBT];
            out_data_reg.winding_fault    <= fault_reg[FLT_WIND];
            out_data_reg.current_fault    <= fault_reg[FLT_CUR];
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= CONTROL_RST;
            igbt_start_reg <= IGBT_START_RST;
            wind_start_reg <= WIND_START_RST;
            cur_start_reg  <= CUR_START_RST;
            igbt_fault_reg <= IGBT_FAULT_RST;
            wind_fault_reg <= WIND_FAULT_RST;
            cur_cutoff_reg <= CUR_CUTOFF_RST;
            rate_reg       <= RAMP_RATE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CONTROL:    control_reg    <= cfg_data[CTRL_W-1:0];
                REG_IGBT_START: igbt_start_reg <= cfg_data[DEG_W-1:0];
                REG_WIND_START: wind_start_reg <= cfg_data[DEG_W-1:0];
                REG_CUR_START:  cur_start_reg  <= cfg_data[CUR_W-1:0];
                REG_IGBT_FAULT: igbt_fault_reg <= cfg_data[DEG_W-1:0];
                REG_WIND_FAULT: wind_fault_reg <= cfg_data[DEG_W-1:0];
                REG_CUR_CUTOFF: cur_cutoff_reg <= cfg_data[CUR_W-1:0];
                REG_RAMP_RATE:
                begin
                    // slopes above the maximum are dropped
                    if (cfg_data[RATE_W-1:0] <= RATE_MAX)
                    begin
                        rate_reg <= cfg_data[RATE_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // one sample in flight at a time
    a_accept_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while another is in flight");

    // faults only ever set
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((fault_reg & $past(fault_reg)) == $past(fault_reg)))
        else $error("sticky fault cleared");

    // degree divide finishes only while the sequencer waits for it
    a_deg_done: assert property (@(posedge clk) disable iff (!rst_n)
        deg_done |-> state_reg == ST_DEG)
        else $error("degree divide finished outside its wait state");

    // scaling finishes only while the sequencer waits for it
    a_scl_done: assert property (@(posedge clk) disable iff (!rst_n)
        scl_done |-> state_reg == ST_SCALE)
        else $error("speed scaling finished outside its wait state");

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import msd_pkg::*;

    typedef longint unsigned u64_t;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned PHASES          = 10;
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned SETTLE_CYCLES   = 80;

    // expected result tracking: mirrors the derating channels and sticky faults
    class derate_scoreboard;
        logic [CTRL_W-1:0]  ctl;
        logic [DEG_W-1:0]   igbt_start;
        logic [DEG_W-1:0]   wind_start;
        logic [CUR_W-1:0]   cur_start;
        logic [DEG_W-1:0]   igbt_limit;
        logic [DEG_W-1:0]   wind_limit;
        logic [CUR_W-1:0]   cur_cutoff;
        logic [RATE_W-1:0]  ramp;
        logic [SPEED_W-1:0] igbt_hold;
        logic [SPEED_W-1:0] wind_hold;
        logic [SPEED_W-1:0] cur_hold;
        logic [FLT_W-1:0]   faults;
        msd_out_t           expected_beats[$];
        int unsigned        errors;

        function new();
            ctl        = CONTROL_RST;
            igbt_start = IGBT_START_RST;
            wind_start = WIND_START_RST;
            cur_start  = CUR_START_RST;
            igbt_limit = IGBT_FAULT_RST;
            wind_limit = WIND_FAULT_RST;
            cur_cutoff = CUR_CUTOFF_RST;
            ramp       = RAMP_RATE_RST;
            igbt_hold  = '0;
            wind_hold  = '0;
            cur_hold   = '0;
            faults     = '0;
            errors     = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_CONTROL:    ctl        = val[CTRL_W-1:0];
                REG_IGBT_START: igbt_start = val[DEG_W-1:0];
                REG_WIND_START: wind_start = val[DEG_W-1:0];
                REG_CUR_START:  cur_start  = val[CUR_W-1:0];
                REG_IGBT_FAULT: igbt_limit = val[DEG_W-1:0];
                REG_WIND_FAULT: wind_limit = val[DEG_W-1:0];
                REG_CUR_CUTOFF: cur_cutoff = val[CUR_W-1:0];
                REG_RAMP_RATE:
                begin
                    // out-of-range slopes leave the old value in place
                    if (val[RATE_W-1:0] <= RATE_MAX)
                        ramp = val[RATE_W-1:0];
                end
            endcase
        endfunction

        // speed * (base - drop) / base, floored at zero
        function logic [SPEED_W-1:0] scale_speed(u64_t speed, u64_t base, u64_t drop);
            logic [63:0] q;
            if (drop >= base)
                return '0;
            q = (speed * (base - drop)) / base;
            return q[SPEED_W-1:0];
        endfunction

        // temperature channel with 3 degC restore band, restore clamped at zero
        function logic [SPEED_W-1:0] temp_hold(logic [SPEED_W-1:0] held, int unsigned t,
                                               int unsigned start, int unsigned speed);
            int unsigned restore;
            restore = (start >= 3) ? start - 3 : 0;
            if (t >= start)
                return scale_speed(speed, 100, u64_t'(ramp) * (t - start));
            if (t < restore)
                return speed[SPEED_W-1:0];
            return held;
        endfunction

        function void note_sample(msd_in_t s);
            int unsigned        t_igbt;
            int unsigned        t_wind;
            int unsigned        ma;
            int unsigned        speed;
            u64_t               start_ma;
            u64_t               restore_ma;
            logic [SPEED_W-1:0] target;
            msd_out_t           beat;
            t_igbt = s.igbt_temp_centideg / 100;
            t_wind = s.winding_temp_centideg / 100;
            ma     = s.current_ma;
            speed  = s.speed_rpm;

            if (ctl[CTL_EN_IGBT])
                igbt_hold = temp_hold(igbt_hold, t_igbt, igbt_start, speed);
            if (!ctl[CTL_BYP_IGBT] && t_igbt > igbt_limit)
                faults[FLT_IGBT] = 1'b1;

            if (ctl[CTL_EN_WIND])
                wind_hold = temp_hold(wind_hold, t_wind, wind_start, speed);
            if (!ctl[CTL_BYP_WIND] && t_wind > wind_limit)
                faults[FLT_WIND] = 1'b1;

            // current channel in milliamps, 2 A restore band
            if (ctl[CTL_EN_CUR])
            begin
                start_ma   = u64_t'(cur_start) * 10;
                restore_ma = (start_ma >= 2000) ? start_ma - 2000 : 0;
                if (ma >= start_ma)
                    cur_hold = scale_speed(speed, 100000, u64_t'(ramp) * (ma - start_ma));
                else if (ma < restore_ma)
                    cur_hold = speed[SPEED_W-1:0];
            end
            if (!ctl[CTL_BYP_CUR] && u64_t'(ma) > u64_t'(cur_cutoff) * 10)
                faults[FLT_CUR] = 1'b1;

            // minimum over enabled channels, seeded with speed
            target = speed[SPEED_W-1:0];
            if (ctl[CTL_EN_CUR])
                target = cur_hold;
            if (ctl[CTL_EN_WIND] && wind_hold < target)
                target = wind_hold;
            if (ctl[CTL_EN_IGBT] && igbt_hold < target)
                target = igbt_hold;

            beat.target_speed_rpm = target;
            beat.igbt_fault       = faults[FLT_IGBT];
            beat.winding_fault    = faults[FLT_WIND];
            beat.current_fault    = faults[FLT_CUR];
            expected_beats.push_back(beat);
        endfunction

        function void check_result(msd_out_t got);
            msd_out_t want;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: speed %0d faults %b%b%b",
                             got.target_speed_rpm, got.igbt_fault, got.winding_fault,
                             got.current_fault);
                return;
            end
            want = expected_beats.pop_front();
            if (got.target_speed_rpm !== want.target_speed_rpm ||
                got.igbt_fault !== want.igbt_fault ||
                got.winding_fault !== want.winding_fault ||
                got.current_fault !== want.current_fault)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected speed %0d faults %b%b%b, got speed %0d faults %b%b%b",
                             want.target_speed_rpm, want.igbt_fault, want.winding_fault,
                             want.current_fault, got.target_speed_rpm, got.igbt_fault,
                             got.winding_fault, got.current_fault);
            end
        endfunction

        function int unsigned outstanding();
            return expected_beats.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    msd_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    msd_out_t              out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    derate_scoreboard sb = new();
    int unsigned      cycle_count = 0;
    bit               idle_on = 1'b1;

    motor_speed_derating_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // receiver backpressure in random bursts
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic msd_in_t make_sample(logic [15:0] igbt, logic [15:0] wind,
                                            logic [15:0] ma, logic [15:0] speed);
        msd_in_t s;
        s.igbt_temp_centideg    = igbt;
        s.winding_temp_centideg = wind;
        s.current_ma            = ma;
        s.speed_rpm             = speed;
        return s;
    endfunction

    // temperature around the start level, the fault level, or anywhere
    function automatic logic [15:0] pick_temp(int unsigned start, int unsigned limit);
        int unsigned t;
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                t = start + $urandom_range(0, 20);
                t = (t >= 6) ? t - 6 : 0;
            end
            6, 7:
            begin
                t = limit + $urandom_range(0, 4);
                t = (t >= 2) ? t - 2 : 0;
            end
            8:
                return 16'($urandom);
            default:
                return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        v = t * 100 + $urandom_range(0, 99);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // current around the derating start, the cutoff, or anywhere
    function automatic logic [15:0] pick_current(int unsigned start, int unsigned cutoff);
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                v = start * 10 + $urandom_range(0, 6000);
                v = (v >= 3000) ? v - 3000 : 0;
            end
            6, 7:
            begin
                v = cutoff * 10 + $urandom_range(0, 40);
                v = (v >= 20) ? v - 20 : 0;
            end
            8:
                return 16'($urandom);
            default:
                return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic msd_in_t random_sample();
        logic [15:0] speed;
        speed = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                            : 16'($urandom);
        return make_sample(pick_temp(sb.igbt_start, sb.igbt_limit),
                           pick_temp(sb.wind_start, sb.wind_limit),
                           pick_current(sb.cur_start, sb.cur_cutoff), speed);
    endfunction

    // input beat with an optional leading gap
    task automatic send_sample(msd_in_t s);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(s);
    endtask

    task automatic send(logic [15:0] igbt, logic [15:0] wind, logic [15:0] ma,
                        logic [15:0] speed);
        send_sample(make_sample(igbt, wind, ma, speed));
    endtask

    // hold off until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_degrees();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 200));
    endfunction

    function automatic logic [15:0] pick_centiamps();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 6553));
    endfunction

    // register settings for one random phase; unused upper data bits are noise
    task automatic program_phase(int unsigned ph);
        logic [CTRL_W-1:0] ctl;
        logic [7:0]        igbt_s;
        logic [7:0]        wind_s;
        logic [15:0]       cur_s;
        logic [7:0]        igbt_f;
        logic [7:0]        wind_f;
        logic [15:0]       cut;
        logic [3:0]        rate;
        ctl    = CTRL_W'($urandom);
        igbt_s = pick_degrees();
        wind_s = pick_degrees();
        cur_s  = pick_centiamps();
        igbt_f = 8'($urandom);
        wind_f = 8'($urandom);
        cut    = pick_centiamps();
        rate   = 4'($urandom);
        if (ph == 0)
        begin
            igbt_s = '0;
            wind_s = '0;
            cur_s  = '0;
            igbt_f = '0;
            wind_f = '0;
            cut    = '0;
            rate   = '0;
        end
        else if (ph == 1)
        begin
            ctl    = '1;
            igbt_s = '1;
            wind_s = '1;
            cur_s  = '1;
            igbt_f = '1;
            wind_f = '1;
            cut    = '1;
            rate   = RATE_MAX;
        end
        // faults stay bypassed until the closing phases
        if (ph < PHASES - 2)
        begin
            ctl[CTL_BYP_IGBT] = 1'b1;
            ctl[CTL_BYP_WIND] = 1'b1;
            ctl[CTL_BYP_CUR]  = 1'b1;
        end
        write_reg(REG_CONTROL, {10'($urandom), ctl});
        write_reg(REG_IGBT_START, {8'($urandom), igbt_s});
        write_reg(REG_WIND_START, {8'($urandom), wind_s});
        write_reg(REG_CUR_START, cur_s);
        write_reg(REG_IGBT_FAULT, {8'($urandom), igbt_f});
        write_reg(REG_WIND_FAULT, {8'($urandom), wind_f});
        write_reg(REG_CUR_CUTOFF, cut);
        write_reg(REG_RAMP_RATE, {12'($urandom), rate});
    endtask

    // stimulus
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_CONTROL;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no channel enabled, values right at the fault limits
        send(16'd0, 16'd0, 16'd0, 16'd0);
        send(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send(16'd11099, 16'd13099, 16'd20000, 16'd1234);

        // all channels, faults bypassed, steepest slope
        drain_results();
        write_reg(REG_CONTROL, 16'h003F);
        write_reg(REG_RAMP_RATE, 16'd10);
        send(16'd8000, 16'd10000, 16'd10000, 16'd5000);
        send(16'd8599, 16'd9999, 16'd9000, 16'd5000);
        send(16'd9000, 16'd9950, 16'd8500, 16'd5000);
        send(16'd7800, 16'd9900, 16'd9999, 16'd6000);
        send(16'd7699, 16'd12000, 16'd0, 16'd6000);
        send(16'd0, 16'd0, 16'd15000, 16'hFFFF);
        send(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // slope writes above the maximum are dropped
        drain_results();
        write_reg(REG_RAMP_RATE, 16'd11);
        write_reg(REG_RAMP_RATE, 16'd15);
        send(16'd8100, 16'd0, 16'd0, 16'd1000);

        // start levels so low that the restore level clamps at zero
        drain_results();
        write_reg(REG_IGBT_START, 16'd0);
        write_reg(REG_WIND_START, 16'd2);
        write_reg(REG_CUR_START, 16'd100);
        send(16'd0, 16'd100, 16'd999, 16'd4000);
        send(16'd99, 16'd0, 16'd0, 16'd3000);

        // disabled channels keep their holds out of the minimum
        drain_results();
        write_reg(REG_CONTROL, 16'h0038);
        send(16'd20000, 16'd20000, 16'd30000, 16'd777);
        drain_results();
        write_reg(REG_CONTROL, 16'h003A);
        send(16'd0, 16'd10300, 16'd0, 16'd5000);
        drain_results();
        write_reg(REG_RAMP_RATE, 16'd0);
        write_reg(REG_CONTROL, 16'h003D);
        send(16'd25500, 16'd0, 16'hFFFF, 16'd4321);

        // random phases, each with fresh register settings
        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            program_phase(ph);
            idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k == ITEMS_PER_PHASE / 2 && $urandom_range(0, 2) == 0)
                    drain_results();
                send_sample(random_sample());
            end
        end

        // wind down
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/msd_pkg.sv
hw/rtl/msd_cdiv.sv
hw/rtl/msd_scale.sv
hw/rtl/motor_speed_derating_unit.sv
tb/sv/testbench.sv
